/* hdl/bmhq_pkg.sv */
package bmhq_pkg;

    // Heap geometry
    localparam int CAPACITY     = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int ADDR_W       = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int CHILD_W      = ADDR_W + 2;

    // Field widths on the ports
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int KEY_W       = 64;
    localparam int PAY_IO_W    = 32;
    localparam int CNT_IO_W    = 7;
    localparam int ENTRY_W     = KEY_W + PAYLOAD_BITS;
    localparam int IN_DATA_W   = KEY_W + PAY_IO_W;
    localparam int OUT_DATA_W  = 2 * KEY_W + 2 * PAY_IO_W + 1 + CNT_IO_W;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_ISSUE,
        ST_UP_CMP,
        ST_DN_LOAD,
        ST_DN_ISSUE,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_PUSH_START,
        CMD_REJECT_FULL,
        CMD_REJECT_EMPTY,
        CMD_CLEAR,
        CMD_NOP,
        CMD_POP_START,
        CMD_WRITE_E,
        CMD_UP_READ,
        CMD_UP_STEP,
        CMD_DN_LOAD,
        CMD_DN_READ,
        CMD_DN_STEP,
        CMD_DELIVER
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic last_one;
        logic pos_zero;
        logic up_move;
        logic dn_move;
    } dp_status_t;

endpackage

/* hdl/binary_min_heap_queue.sv */
// Sequence: a push sifts up from the new last slot; a pop refills the root from the last
//   entry and sifts down; full, empty, clear, no-op and a pop of the last entry go
//   straight to the result state.
// Throughput: one item at a time; s_tready is high only while idle. Each sift step is
//   one registered RAM read, then one compare+write.
// Reset: aresetn synchronous active low; empties the heap, drops any result.
module binary_min_heap_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: key[63:0], payload[95:64]
    input  logic [bmhq_pkg::IN_DATA_W-1:0]    s_tdata,
    // s_tuser from bit 0: kind[1:0]
    input  logic [bmhq_pkg::KIND_W-1:0]       s_tuser,
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: popped_key[63:0], popped_payload[95:64],
    //   head_valid[96], head_key[160:97], head_payload[192:161],
    //   entry_count[199:193]
    output logic [bmhq_pkg::OUT_DATA_W-1:0]   m_tdata,
    // m_tuser from bit 0: status[1:0]
    output logic [bmhq_pkg::STATUS_W-1:0]     m_tuser
);
    import bmhq_pkg::*;

    // Controller walks the sift loop; datapath owns the heap RAM,
    // the moving entry, the fill count and the result register.
    cmd_t       cmd;
    dp_status_t dp_status;

    bmhq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_kind    (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // Sift moves a hole instead of swapping: the entry in flight stays in a
    // register and is written once, where it comes to rest.
    bmhq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_data    (s_tdata),
        .dp_status  (dp_status),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

endmodule

/* hdl/bmhq_ram.sv */
module bmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        rdata_a <= mem_array[raddr_a];
        rdata_b <= mem_array[raddr_b];
    end

endmodule

/* hdl/bmhq_datapath.sv */
module bmhq_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bmhq_pkg::cmd_t                    cmd,
    input  logic [bmhq_pkg::IN_DATA_W-1:0]    in_data,
    output bmhq_pkg::dp_status_t              dp_status,
    output logic [bmhq_pkg::OUT_DATA_W-1:0]   out_data,
    output logic [bmhq_pkg::STATUS_W-1:0]     out_status
);
    import bmhq_pkg::*;

    logic [KEY_W-1:0]        e_key_reg, e_key_next;
    logic [PAYLOAD_BITS-1:0] e_pay_reg, e_pay_next;
    logic [ADDR_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [KEY_W-1:0]        head_key_reg, head_key_next;
    logic [PAYLOAD_BITS-1:0] head_pay_reg, head_pay_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [KEY_W-1:0]        popped_key_reg, popped_key_next;
    logic [PAYLOAD_BITS-1:0] popped_pay_reg, popped_pay_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;

    logic                    we;
    logic [ADDR_W-1:0]       waddr, raddr_a, raddr_b;
    logic [ENTRY_W-1:0]      wdata, rdata_a, rdata_b;

    logic [ADDR_W-1:0]       parent;
    logic [CHILD_W-1:0]      child_l, child_r;
    logic                    l_ok, r_ok, sel_l, sel_r;
    logic [KEY_W-1:0]        key_a, key_b, best_key;
    logic                    head_valid;
    logic [CNT_W-1:0]        count_dec;

    bmhq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // Entries are stored as {payload, key}
    assign key_a     = rdata_a[KEY_W-1:0];
    assign key_b     = rdata_b[KEY_W-1:0];
    assign parent    = (pos_reg - ADDR_W'(1)) >> 1;
    assign child_l   = {1'b0, pos_reg, 1'b1};
    assign child_r   = child_l + CHILD_W'(1);
    assign l_ok      = child_l < CHILD_W'(count_reg);
    assign r_ok      = child_r < CHILD_W'(count_reg);
    assign sel_l     = l_ok && (key_a < e_key_reg);
    assign best_key  = sel_l ? key_a : e_key_reg;
    assign sel_r     = r_ok && (key_b < best_key);
    assign count_dec = count_reg - CNT_W'(1);
    assign head_valid = (count_reg != '0);

    assign dp_status.full     = (count_reg >= CNT_W'(CAPACITY));
    assign dp_status.empty    = (count_reg == '0);
    assign dp_status.last_one = (count_reg == CNT_W'(1));
    assign dp_status.pos_zero = (pos_reg == '0);
    assign dp_status.up_move  = (e_key_reg < key_a);
    assign dp_status.dn_move  = sel_l || sel_r;

    always_comb begin
        e_key_next      = e_key_reg;
        e_pay_next      = e_pay_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        popped_key_next = popped_key_reg;
        popped_pay_next = popped_pay_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        we              = 1'b0;
        waddr           = pos_reg;
        wdata           = {e_pay_reg, e_key_reg};
        raddr_a         = child_l[ADDR_W-1:0];
        raddr_b         = child_r[ADDR_W-1:0];

        unique case (cmd)
            CMD_PUSH_START: begin
                e_key_next      = in_data[KEY_W-1:0];
                e_pay_next      = PAYLOAD_BITS'(in_data[KEY_W +: PAY_IO_W]);
                pos_next        = count_reg[ADDR_W-1:0];
                count_next      = count_reg + CNT_W'(1);
                status_next     = STATUS_OK;
                popped_key_next = '0;
                popped_pay_next = '0;
            end
            CMD_REJECT_FULL: begin
                status_next     = STATUS_FULL;
                popped_key_next = '0;
                popped_pay_next = '0;
            end
            CMD_REJECT_EMPTY: begin
                status_next     = STATUS_EMPTY;
                popped_key_next = '0;
                popped_pay_next = '0;
            end
            CMD_CLEAR: begin
                count_next      = '0;
                status_next     = STATUS_OK;
                popped_key_next = '0;
                popped_pay_next = '0;
            end
            CMD_NOP: begin
                status_next     = STATUS_OK;
                popped_key_next = '0;
                popped_pay_next = '0;
            end
            CMD_POP_START: begin
                // root leaves; fetch the last entry to refill it
                popped_key_next = head_key_reg;
                popped_pay_next = head_pay_reg;
                count_next      = count_dec;
                status_next     = STATUS_OK;
                raddr_a         = count_dec[ADDR_W-1:0];
            end
            CMD_WRITE_E: begin
                we = 1'b1;
            end
            CMD_UP_READ: begin
                raddr_a = parent;
            end
            CMD_UP_STEP: begin
                we = 1'b1;
                if (dp_status.up_move) begin
                    wdata    = rdata_a;
                    pos_next = parent;
                end
            end
            CMD_DN_LOAD: begin
                e_key_next = key_a;
                e_pay_next = rdata_a[KEY_W +: PAYLOAD_BITS];
                pos_next   = '0;
            end
            CMD_DN_READ: begin
                // child addresses are the defaults
            end
            CMD_DN_STEP: begin
                we = 1'b1;
                if (sel_r) begin
                    wdata    = rdata_b;
                    pos_next = child_r[ADDR_W-1:0];
                end else if (sel_l) begin
                    wdata    = rdata_a;
                    pos_next = child_l[ADDR_W-1:0];
                end
            end
            CMD_DELIVER: begin
                out_status_next = status_reg;
                out_data_next   = {
                    CNT_IO_W'(count_reg),
                    head_valid ? PAY_IO_W'(head_pay_reg) : PAY_IO_W'(0),
                    head_valid ? head_key_reg : KEY_W'(0),
                    head_valid,
                    PAY_IO_W'(popped_pay_reg),
                    popped_key_reg
                };
            end
            default: begin
            end
        endcase

        // Root copy tracks every write to slot zero
        head_key_next = head_key_reg;
        head_pay_next = head_pay_reg;
        if (we && (waddr == '0)) begin
            head_key_next = wdata[KEY_W-1:0];
            head_pay_next = wdata[KEY_W +: PAYLOAD_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_key_reg      <= e_key_next;
        e_pay_reg      <= e_pay_next;
        pos_reg        <= pos_next;
        head_key_reg   <= head_key_next;
        head_pay_reg   <= head_pay_next;
        status_reg     <= status_next;
        popped_key_reg <= popped_key_next;
        popped_pay_reg <= popped_pay_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule

/* hdl/bmhq_ctrl.sv */
module bmhq_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bmhq_pkg::KIND_W-1:0]   s_kind,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  bmhq_pkg::dp_status_t          dp_status,
    output bmhq_pkg::cmd_t                cmd
);
    import bmhq_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        s_tready   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (s_kind)
                        KIND_PUSH: begin
                            if (dp_status.full) begin
                                cmd        = CMD_REJECT_FULL;
                                state_next = ST_DONE;
                            end else begin
                                cmd        = CMD_PUSH_START;
                                state_next = ST_UP_ISSUE;
                            end
                        end
                        KIND_POP: begin
                            if (dp_status.empty) begin
                                cmd        = CMD_REJECT_EMPTY;
                                state_next = ST_DONE;
                            end else begin
                                cmd        = CMD_POP_START;
                                state_next = dp_status.last_one ? ST_DONE : ST_DN_LOAD;
                            end
                        end
                        KIND_CLEAR: begin
                            cmd        = CMD_CLEAR;
                            state_next = ST_DONE;
                        end
                        default: begin
                            cmd        = CMD_NOP;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_UP_ISSUE: begin
                if (dp_status.pos_zero) begin
                    cmd        = CMD_WRITE_E;
                    state_next = ST_DONE;
                end else begin
                    cmd        = CMD_UP_READ;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                cmd        = CMD_UP_STEP;
                state_next = dp_status.up_move ? ST_UP_ISSUE : ST_DONE;
            end
            ST_DN_LOAD: begin
                cmd        = CMD_DN_LOAD;
                state_next = ST_DN_ISSUE;
            end
            ST_DN_ISSUE: begin
                cmd        = CMD_DN_READ;
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                cmd        = CMD_DN_STEP;
                state_next = dp_status.dn_move ? ST_DN_ISSUE : ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd        = CMD_DELIVER;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd == CMD_DELIVER) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

/* hdl/bmhq_checker.sv */
module bmhq_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bmhq_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [bmhq_pkg::STATUS_W-1:0]     m_tuser
);
    import bmhq_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Head flag agrees with the count
    a_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[96] == (m_tdata[199:193] != 7'd0)))
        else $error("head_valid disagrees with entry_count");

    // Count never exceeds the capacity
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[199:193] <= CNT_IO_W'(CAPACITY)))
        else $error("entry_count above capacity");

    // Refused operations return nothing
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata[95:0] == 96'd0))
        else $error("popped fields set on a refused operation");

    // No result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind binary_min_heap_queue bmhq_checker u_checker (.*);
